>>> sv/float_bad_pixel_repair_core_macros.svh
// Assertion macros for the pixel repair core
`ifndef FLOAT_BAD_PIXEL_REPAIR_CORE_MACROS_SVH
`define FLOAT_BAD_PIXEL_REPAIR_CORE_MACROS_SVH
// Check that a condition implies a consequence in the same cycle
`define FBPR_ASSERT_IMPLY(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("check failed");
// Check that a condition implies a consequence in the next cycle
`define FBPR_ASSERT_NEXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("check failed");
`endif

>>> sv/fbpr_pkg.sv
`default_nettype none
package fbpr_pkg;
  localparam logic [31:0] QNAN = 32'h7FC0_0000;
  localparam int          GUARD = 30;
  localparam int          MW = 24 + GUARD + 2;

  typedef struct packed {
    logic [31:0] center;
    logic [31:0] left;
    logic [31:0] right;
    logic [31:0] up;
    logic [31:0] down;
  } in_word_t;

  typedef struct packed {
    logic [31:0] result;
    logic        replaced;
  } out_word_t;

  // Combinational full IEEE single add, nearest even, canonical NaN
  function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
    logic        sa, sb, st, sl;
    logic [7:0]  ea, eb, et;
    logic [MW-1:0] ma, mb, mt, v, lost;
    logic [9:0]  e;
    logic [7:0]  d;
    logic [5:0]  lz;
    logic [MW-1:0] r;
    logic [GUARD-1:0] rem;
    logic [31:0] res;
    sa = a[31]; sb = b[31];
    ea = a[30:23]; eb = b[30:23];
    ma = MW'({(ea != 8'd0), a[22:0]}) << GUARD;
    mb = MW'({(eb != 8'd0), b[22:0]}) << GUARD;
    res = 32'd0;
    lz = 6'd0;
    if ((ea == 8'hFF && a[22:0] != 0) || (eb == 8'hFF && b[22:0] != 0)) res = QNAN;
    else if (ea == 8'hFF) res = (eb == 8'hFF && sa != sb) ? QNAN : a;
    else if (eb == 8'hFF) res = b;
    else if (a[30:0] == 0 && b[30:0] == 0) res = {sa & sb, 31'd0};
    else if (a[30:0] == 0) res = b;
    else if (b[30:0] == 0) res = a;
    else begin
      if (ea == 8'd0) ea = 8'd1;
      if (eb == 8'd0) eb = 8'd1;
      if (eb > ea || (eb == ea && mb > ma)) begin
        mt = ma; ma = mb; mb = mt;
        et = ea; ea = eb; eb = et;
        st = sa; sa = sb; sb = st;
      end
      d = ea - eb;
      if (d >= 8'd56) mb = MW'(mb != 0);
      else if (d != 8'd0) begin
        lost = mb & ((MW'(1) << d) - MW'(1));
        mb = (mb >> d) | MW'(lost != 0);
      end
      v = (sa == sb) ? ma + mb : ma - mb;
      if (v == 0) res = 32'd0;
      else begin
        e = {2'b00, ea};
        if (v[54]) begin
          v = (v >> 1) | MW'(v[0]);
          e = e + 10'd1;
        end
        for (int i = 53; i >= 0; i--) if (v[i] && lz == 6'd0 && i != 53) lz = 6'(53 - i);
        if (v[53]) lz = 6'd0;
        if (10'(lz) > e - 10'd1) lz = 6'(e - 10'd1);
        v = v << lz;
        e = e - 10'(lz);
        r = v >> GUARD;
        rem = v[GUARD-1:0];
        sl = r[0];
        if (rem > (GUARD'(1) << (GUARD - 1)) || (rem == (GUARD'(1) << (GUARD - 1)) && sl))
          r = r + MW'(1);
        if (r[24]) begin
          r = r >> 1;
          e = e + 10'd1;
        end
        if (e >= 10'd255) res = {sa, 8'hFF, 23'd0};
        else res = {sa, (r[23] ? e[7:0] : 8'd0), r[22:0]};
      end
    end
    return res;
  endfunction

  // Divide by four with nearest even rounding into the subnormal range
  function automatic logic [31:0] fquarter(input logic [31:0] x);
    logic [23:0] m, q, rem, half;
    logic [1:0]  sh;
    logic [31:0] res;
    m = {(x[30:23] != 8'd0), x[22:0]};
    sh = (x[30:23] == 8'd0) ? 2'd2 : 2'(3 - x[24:23]);
    q = m >> sh;
    rem = m & ((24'd1 << sh) - 24'd1);
    half = 24'd1 << (sh - 2'd1);
    if (rem > half || (rem == half && q[0])) q = q + 24'd1;
    if (x[30:23] == 8'hFF) res = (x[22:0] != 0) ? QNAN : x;
    else if (x[30:0] == 0) res = x;
    else if (x[30:23] >= 8'd3) res = x - (32'd2 << 23);
    else res = {x[31], 7'd0, q};
    return res;
  endfunction
endpackage
`default_nettype wire

>>> sv/fbpr_if.sv
`default_nettype none
interface fbpr_in_if (input wire logic clk);
  logic valid;
  logic ready;
  fbpr_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fbpr_out_if (input wire logic clk);
  logic valid;
  logic ready;
  fbpr_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/fbpr_add_stage.sv
`default_nettype none
module fbpr_add_stage (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        adv,
  input  wire logic        in_valid,
  input  wire logic [31:0] acc_in,
  input  wire logic [31:0] term,
  input  wire logic        bad_in,
  input  wire logic [31:0] center_in,
  input  wire logic [95:0] rest_in,
  output logic             out_valid,
  output logic [31:0]      acc_out,
  output logic             bad_out,
  output logic [31:0]      center_out,
  output logic [95:0]      rest_out
);
  // Add one neighbour and shift the remaining ones along
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= in_valid;
    if (adv) begin
      acc_out    <= fbpr_pkg::fadd(acc_in, term);
      bad_out    <= bad_in;
      center_out <= center_in;
      rest_out   <= {rest_in[63:0], 32'd0};
    end
  end
endmodule
`default_nettype wire

>>> sv/float_bad_pixel_repair_core.sv
// Channel | dir | word
// in      | in  | center, left, right, up, down bits
// out     | out | result bits, replaced flag
// One word per cycle while the output is not stalled; four add stages, one scale stage.
// Each stage holds one fadd or the quarter scaling.
// Synchronous reset empties the pipeline.
// A stall at the output freezes all stages; nothing is lost or repeated.
`default_nettype none
`include "float_bad_pixel_repair_core_macros.svh"
module float_bad_pixel_repair_core (
  input wire logic clk,
  input wire logic rst,
  fbpr_in_if.sink    in,
  fbpr_out_if.source out
);
  logic        adv;
  logic [4:0]  v;
  logic [31:0] acc [5];
  logic [4:0]  bad;
  logic [31:0] cen [5];
  logic [95:0] rest [5];
  logic        ov;
  fbpr_pkg::out_word_t od;
  logic [31:0] dn [3];

  // Advance whenever the output slot is empty or being taken
  assign adv = !ov || out.ready;
  assign in.ready = adv;

  assign v[0]    = in.valid;
  assign acc[0]  = 32'd0;
  assign bad[0]  = (in.data.center[30:23] == 8'hFF);
  assign cen[0]  = in.data.center;
  assign rest[0] = {in.data.left, in.data.right, in.data.up};

  // Down neighbour rides in a delay line to meet the last adder
  always_ff @(posedge clk) begin
    if (adv) begin
      dn[0] <= in.data.down;
      dn[1] <= dn[0];
      dn[2] <= dn[1];
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_add
    fbpr_add_stage u_add (
      .clk(clk), .rst(rst), .adv(adv), .in_valid(v[i]), .acc_in(acc[i]),
      .term(i == 3 ? dn[2] : rest[i][95:64]),
      .bad_in(bad[i]), .center_in(cen[i]), .rest_in(rest[i]),
      .out_valid(v[i+1]), .acc_out(acc[i+1]), .bad_out(bad[i+1]),
      .center_out(cen[i+1]), .rest_out(rest[i+1])
    );
  end

  // Scale and select, held in the output register
  always_ff @(posedge clk) begin
    if (rst) ov <= 1'b0;
    else if (adv) ov <= v[4];
    if (adv) begin
      od.replaced <= bad[4];
      od.result   <= bad[4] ? fbpr_pkg::fquarter(acc[4]) : cen[4];
    end
  end
  assign out.valid = ov;
  assign out.data  = od;

  `FBPR_ASSERT_NEXT(a_hold, clk, rst, ov && !out.ready, ov && $stable(od))
  `FBPR_ASSERT_IMPLY(a_ready, clk, rst, !ov, in.ready)
  `FBPR_ASSERT_IMPLY(a_pass, clk, rst, ov && !od.replaced, od.result[30:23] != 8'hFF)
endmodule
`default_nettype wire
